[hdl/bmp_to_a1rgb5_converter_macros.svh]
// Assertion helpers shared by the converter modules.
`ifndef BMP_TO_A1RGB5_CONVERTER_MACROS_SVH
`define BMP_TO_A1RGB5_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define BMPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmpc assertion failed");
`define BMPC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bmpc assertion failed");
`else
`define BMPC_ASSERT(label, clk, rst, prop)
`define BMPC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hdl/bmpc_pkg.sv]
`default_nettype none

package bmpc_pkg;

   localparam int MAX_DIM    = 1024;
   localparam int DIM_W      = $clog2(MAX_DIM);
   localparam int CFG_W      = $clog2(MAX_DIM + 1);

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int KEY_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ENABLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR    = 3'd4;

   localparam logic DEPTH_16 = 1'b0;
   localparam logic DEPTH_24 = 1'b1;

   // index of the closing byte of a pixel
   localparam logic [1:0] LAST_IDX_16 = 2'd1;
   localparam logic [1:0] LAST_IDX_24 = 2'd2;

   localparam logic [WORD_W-1:0] OPAQUE_BIT   = 16'h8000;
   localparam logic [WORD_W-1:0] KEYED_WORD   = 16'h0000;
   localparam logic [14:0]       KEY15_MASK   = 15'h7FFF;

   typedef struct packed {
      logic              depth_mode;
      logic              key_enable;
      logic [KEY_W-1:0]  key_color;
      logic [1:0]        pad_bytes;   // padding bytes after each row
   } bmpc_cfg_type;

endpackage

`default_nettype wire

[hdl/bmpc_channels.sv]
`default_nettype none

interface bmpc_req_if;
   logic                      valid;
   logic                      ready;
   logic [bmpc_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface bmpc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bmpc_pkg::WORD_W-1:0] pixel_word;
   logic [bmpc_pkg::DIM_W-1:0]  column;
   logic [bmpc_pkg::DIM_W-1:0]  row;
   logic                        last_pixel;

   modport source (output valid, output pixel_word, output column, output row,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_word, input column, input row,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

[hdl/bmpc_csr.sv]
`default_nettype none

module bmpc_csr #(
   parameter int MAX_DIM = 1024,
   parameter int DIM_W   = 10,
   parameter int CFG_W   = 11
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [bmpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bmpc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output bmpc_pkg::bmpc_cfg_type                 cfg,
   output logic [DIM_W-1:0]                       width_m1,
   output logic [DIM_W-1:0]                       height_m1
);

   logic [DIM_W-1:0]              width_m1_ff, width_m1_in;
   logic [DIM_W-1:0]              height_m1_ff, height_m1_in;
   logic                          depth_ff, depth_in;
   logic                          key_en_ff, key_en_in;
   logic [bmpc_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [CFG_W-1:0]              raw_dim;
   logic [DIM_W-1:0]              clamped_m1;
   logic [1:0]                    width_lsb;

   // zero acts as one, anything above MAX_DIM acts as MAX_DIM
   assign raw_dim = csr_write_data[CFG_W-1:0];

   always_comb begin
      if (raw_dim == '0) begin
         clamped_m1 = '0;
      end else if (raw_dim > CFG_W'(MAX_DIM)) begin
         clamped_m1 = DIM_W'(MAX_DIM - 1);
      end else begin
         clamped_m1 = DIM_W'(raw_dim - CFG_W'(1));
      end
   end

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      depth_in     = depth_ff;
      key_en_in    = key_en_ff;
      key_in       = key_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bmpc_pkg::CSR_IMAGE_WIDTH:  width_m1_in  = clamped_m1;
            bmpc_pkg::CSR_IMAGE_HEIGHT: height_m1_in = clamped_m1;
            bmpc_pkg::CSR_DEPTH_MODE:   depth_in     = csr_write_data[0];
            bmpc_pkg::CSR_KEY_ENABLE:   key_en_in    = csr_write_data[0];
            bmpc_pkg::CSR_KEY_COLOR:    key_in       = csr_write_data[bmpc_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= '0;
         height_m1_ff <= '0;
         depth_ff     <= bmpc_pkg::DEPTH_16;
         key_en_ff    <= 1'b0;
         key_ff       <= '0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         depth_ff     <= depth_in;
         key_en_ff    <= key_en_in;
         key_ff       <= key_in;
      end
   end

   // width mod 4; 24-bit rows pad by w mod 4, 16-bit rows by 2 when w is odd
   assign width_lsb = width_m1_ff[1:0] + 2'd1;

   always_comb begin
      cfg.depth_mode = depth_ff;
      cfg.key_enable = key_en_ff;
      cfg.key_color  = key_ff;
      if (depth_ff == bmpc_pkg::DEPTH_24) begin
         cfg.pad_bytes = width_lsb;
      end else begin
         cfg.pad_bytes = width_lsb[0] ? 2'd2 : 2'd0;
      end
   end

   assign width_m1  = width_m1_ff;
   assign height_m1 = height_m1_ff;

endmodule

`default_nettype wire

[hdl/bmpc_pixel.sv]
`default_nettype none

`include "bmp_to_a1rgb5_converter_macros.svh"

module bmpc_pixel #(
   parameter int DIM_W = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic [bmpc_pkg::BYTE_W-1:0]     data_byte,
   input  wire bmpc_pkg::bmpc_cfg_type          cfg,
   input  wire logic [DIM_W-1:0]                width_m1,
   input  wire logic [DIM_W-1:0]                height_m1,
   output logic                                 produce,
   output logic [bmpc_pkg::WORD_W-1:0]          pixel_word,
   output logic [DIM_W-1:0]                     column,
   output logic [DIM_W-1:0]                     row,
   output logic                                 last_pixel
);

   logic [15:0]       asm_ff, asm_in;
   logic [1:0]        bip_ff, bip_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  frow_ff, frow_in;
   logic [1:0]        pad_ff, pad_in;

   logic [1:0]        last_idx;
   logic              padding;
   logic              assembling;
   logic              last_col;
   logic              last_row;
   logic [14:0]       swapped;
   logic [23:0]       bgr;

   assign last_idx   = (cfg.depth_mode == bmpc_pkg::DEPTH_24) ?
                       bmpc_pkg::LAST_IDX_24 : bmpc_pkg::LAST_IDX_16;
   assign padding    = (pad_ff != 2'd0);
   assign assembling = (bip_ff < last_idx);
   assign produce    = !padding && !assembling;

   assign last_col = (col_ff >= width_m1);
   assign last_row = (frow_ff >= height_m1);

   // 16-bit source: swap red and blue so red sits in the low bits
   assign swapped = {asm_ff[4:0], data_byte[1:0], asm_ff[7:5], data_byte[6:2]};
   assign bgr     = {data_byte, asm_ff[15:8], asm_ff[7:0]};

   always_comb begin
      if (cfg.depth_mode == bmpc_pkg::DEPTH_16) begin
         if (cfg.key_enable && swapped == (cfg.key_color[14:0] & bmpc_pkg::KEY15_MASK)) begin
            pixel_word = bmpc_pkg::KEYED_WORD;
         end else begin
            pixel_word = {1'b0, swapped} | bmpc_pkg::OPAQUE_BIT;
         end
      end else begin
         if (cfg.key_enable && bgr == cfg.key_color) begin
            pixel_word = bmpc_pkg::KEYED_WORD;
         end else begin
            pixel_word = {1'b0, asm_ff[7:3], asm_ff[15:11], data_byte[7:3]} |
                         bmpc_pkg::OPAQUE_BIT;
         end
      end
   end

   assign column     = col_ff;
   assign row        = last_row ? '0 : (height_m1 - frow_ff);
   assign last_pixel = last_col && last_row;

   always_comb begin
      asm_in  = asm_ff;
      bip_in  = bip_ff;
      col_in  = col_ff;
      frow_in = frow_ff;
      pad_in  = pad_ff;
      if (fire) begin
         if (padding) begin
            pad_in = pad_ff - 2'd1;
         end else if (assembling) begin
            if (bip_ff == 2'd0) begin
               asm_in[7:0] = data_byte;
            end else begin
               asm_in[15:8] = data_byte;
            end
            bip_in = bip_ff + 2'd1;
         end else begin
            bip_in = 2'd0;
            if (last_col) begin
               pad_in  = cfg.pad_bytes;
               col_in  = '0;
               frow_in = last_row ? '0 : (frow_ff + DIM_W'(1));
            end else begin
               col_in = col_ff + DIM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff  <= '0;
         bip_ff  <= '0;
         col_ff  <= '0;
         frow_ff <= '0;
         pad_ff  <= '0;
      end else begin
         asm_ff  <= asm_in;
         bip_ff  <= bip_in;
         col_ff  <= col_in;
         frow_ff <= frow_in;
         pad_ff  <= pad_in;
      end
   end

   `BMPC_ASSERT_ALWAYS(a_bip_range, clock, reset || bip_ff <= bmpc_pkg::LAST_IDX_24)
   `BMPC_ASSERT(a_pad_holds_pixel, clock, reset, fire && padding |=> bip_ff == $past(bip_ff))
   `BMPC_ASSERT(a_image_wraps, clock, reset, fire && produce && last_pixel |=> col_ff == '0 && frow_ff == '0)

endmodule

`default_nettype wire

[hdl/bmp_to_a1rgb5_converter.sv]
// BMP pixel-data to A1RGB5 converter.
// req_ch carries one byte of uncompressed BMP pixel data per transfer, in
// file order (bottom row first, rows padded to 4 bytes). rsp_ch carries one
// transfer per completed pixel: the A1RGB5 word (red in bits 4:0, bit 15
// set unless keyed, 0 when keyed), its column, its top-down row and a flag
// on the final pixel of the image. Padding and partial-pixel bytes produce
// no transfer.
// The csr_ port writes image_width, image_height, depth_mode, key_enable and
// key_color (indexes 0..4); write only while no byte is in flight.
// Throughput: one byte per cycle unless rsp_ch stalls. A byte is first
// taken into the input register; the pixel logic then updates the counters
// and loads the output register, which then drives rsp_ch.valid.
// When rsp_ch stalls, the output register holds its pixel; one more byte can
// still be taken into the input register, after which req_ch.ready drops.
// Reset (synchronous) empties both registers, clears the byte, column, row
// and padding counters and returns the registers to width 1, height 1,
// 16-bit, no key.
`default_nettype none

`include "bmp_to_a1rgb5_converter_macros.svh"

module bmp_to_a1rgb5_converter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bmpc_req_if.sink                               req_ch,
   bmpc_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_write_enable,
   input  wire logic [bmpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bmpc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int DIM_W = bmpc_pkg::DIM_W;
   localparam int CFG_W = bmpc_pkg::CFG_W;

   bmpc_pkg::bmpc_cfg_type         cfg;
   logic [DIM_W-1:0]               width_m1;
   logic [DIM_W-1:0]               height_m1;

   logic                           in_valid_ff, in_valid_in;
   logic [bmpc_pkg::BYTE_W-1:0]    in_byte_ff, in_byte_in;
   logic                           out_valid_ff, out_valid_in;
   logic [bmpc_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [DIM_W-1:0]               col_ff, col_in;
   logic [DIM_W-1:0]               row_ff, row_in;
   logic                           last_ff, last_in;

   logic                           advance;
   logic                           fire;
   logic                           produce;
   logic [bmpc_pkg::WORD_W-1:0]    px_word;
   logic [DIM_W-1:0]               px_col;
   logic [DIM_W-1:0]               px_row;
   logic                           px_last;

   bmpc_csr #(
      .MAX_DIM (bmpc_pkg::MAX_DIM),
      .DIM_W   (DIM_W),
      .CFG_W   (CFG_W)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .width_m1         (width_m1),
      .height_m1        (height_m1)
   );

   // output register free or being drained this cycle
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign fire    = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   bmpc_pixel #(
      .DIM_W (DIM_W)
   ) u_pixel (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .cfg        (cfg),
      .width_m1   (width_m1),
      .height_m1  (height_m1),
      .produce    (produce),
      .pixel_word (px_word),
      .column     (px_col),
      .row        (px_row),
      .last_pixel (px_last)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.data_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      word_in      = word_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = fire && produce;
         word_in      = px_word;
         col_in       = px_col;
         row_in       = px_row;
         last_in      = px_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      word_ff    <= word_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      last_ff    <= last_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pixel_word = word_ff;
   assign rsp_ch.column     = col_ff;
   assign rsp_ch.row        = row_ff;
   assign rsp_ch.last_pixel = last_ff;

   `BMPC_ASSERT(a_result_loaded, clock, reset, fire && produce |=> out_valid_ff)
   `BMPC_ASSERT(a_stall_holds_input, clock, reset, in_valid_ff && out_valid_ff && !rsp_ch.ready |=> in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire
